[sv/olist_pkg.sv]
// Shared codes and types for the ordered list engine.
// No dependencies; used by every other file of the block.
`default_nettype none
package olist_pkg;

   // Default list capacity
   localparam int CAPACITY_DEFAULT = 16;

   // Request codes
   localparam logic [2:0] REQ_APPEND = 3'd0;
   localparam logic [2:0] REQ_REMOVE = 3'd1;
   localparam logic [2:0] REQ_ADD    = 3'd2;
   localparam logic [2:0] REQ_MUL    = 3'd3;
   localparam logic [2:0] REQ_COMB   = 3'd4;
   localparam logic [2:0] REQ_DUMP   = 3'd5;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // Per-cell controls
   typedef struct packed {
      logic shift;   // take the neighbor's value
      logic load;    // take the appended value
   } cell_ctrl_type;

endpackage
`default_nettype wire

[sv/olist_cell.sv]
// One storage cell of the list ring: holds one entry.
// Depends on olist_pkg for the control struct.
`default_nettype none
module olist_cell (
   input  wire logic                   clock,
   input  wire olist_pkg::cell_ctrl_type ctrl,
   input  wire logic [31:0]            nbr_d,
   input  wire logic [31:0]            load_d,
   output logic [31:0]                 q
);

   logic [31:0] entry_ff;
   logic [31:0] entry_in;

   // Select shift from neighbor, load, or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = nbr_d;
      end else if (ctrl.load) begin
         entry_in = load_d;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

[sv/olist_alu.sv]
// Bulk operation unit on the ring's feedback path (head cell to tail cell).
// Depends on olist_pkg for request codes.
`default_nettype none
module olist_alu (
   input  wire logic [2:0]  op,
   input  wire logic        in_use,
   input  wire logic [31:0] entry,
   input  wire logic [31:0] operand,
   output logic [31:0]      result
);

   logic [31:0] sum;
   logic [31:0] prod;

   // Wrap modulo 2^32
   assign sum  = entry + operand;
   assign prod = entry * operand;

   // Apply the operation to live entries, pass everything else
   always_comb begin
      result = entry;
      if (in_use) begin
         case (op)
            olist_pkg::REQ_ADD:  result = sum;
            olist_pkg::REQ_MUL:  result = prod;
            olist_pkg::REQ_COMB: result = sum + prod;
            default:             result = entry;
         endcase
      end
   end

endmodule
`default_nettype wire

[sv/ordered_list_engine_with_bulk_ops_unit.sv]
// Top level of the ordered list engine: control, cell ring and operation unit.
// Depends on olist_pkg, olist_cell and olist_alu.
`default_nettype none
// Keeps up to CAPACITY signed 32-bit entries in order in a ring of cells that
// rotates toward the head, with the operation unit between head and tail.
// A request is taken when start is high and busy is low. Append and a dump of
// an empty list answer in the next cycle and leave busy low. Remove,
// add/multiply/combined-all and a dump of a non-empty list rotate the ring
// once, one entry passing the head cell per cycle; a remove that finds
// its key then closes the gap. Dump results come one per cycle
// during the rotation. Each result appears on the rsp_ ports for exactly one
// cycle with rsp_valid high and cannot be held off by the receiver. Codes 6
// and 7 are taken and give no result.
module ordered_list_engine_with_bulk_ops_unit #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_type,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_element,
   output logic [3:0]              rsp_position,
   output logic                    rsp_last,
   output logic [4:0]              rsp_entry_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {IDLE, ROTATE, COMPACT} state_type;

   state_type   state_ff;
   logic [CW-1:0] used_ff;
   logic [2:0]  op_ff;
   logic [31:0] key_ff;
   logic [IW-1:0] step_ff;
   logic        found_ff;
   logic [IW-1:0] match_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_element_ff;
   logic [IW-1:0] rsp_pos_ff;
   logic        rsp_last_ff;
   logic [CW-1:0] rsp_count_ff;

   logic [31:0] cell_q [CAPACITY];
   olist_pkg::cell_ctrl_type cell_ctrl [CAPACITY];
   logic [31:0] alu_out;

   logic          rotating;
   logic          compacting;
   logic          append_go;
   logic [CW-1:0] step_ext;
   logic          in_use;
   logic          is_bulk;
   logic          hit;
   logic          last_step;
   logic          dump_last;

   // Decode control for this cycle
   assign rotating   = (state_ff == ROTATE);
   assign compacting = (state_ff == COMPACT);
   assign append_go  = (state_ff == IDLE) && start && (req_type == olist_pkg::REQ_APPEND)
                       && (used_ff != CW'(CAPACITY));
   assign step_ext   = CW'(step_ff);
   assign in_use     = step_ext < used_ff;
   assign is_bulk    = (op_ff inside {olist_pkg::REQ_ADD, olist_pkg::REQ_MUL,
                                      olist_pkg::REQ_COMB});
   assign hit        = rotating && (op_ff == olist_pkg::REQ_REMOVE) && in_use && !found_ff
                       && (cell_q[0] == key_ff);
   assign last_step  = (step_ff == IW'(CAPACITY - 1));
   assign dump_last  = (CW'(step_ext + CW'(1)) == used_ff);

   // Operation unit on the feedback path
   olist_alu u_alu (
      .op      (op_ff),
      .in_use  (rotating && in_use && is_bulk),
      .entry   (cell_q[0]),
      .operand (key_ff),
      .result  (alu_out)
   );

   // Ring of cells, each handing its entry toward the head
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [31:0] nbr;
      if (k < CAPACITY - 1) begin : g_mid
         assign nbr = cell_q[k+1];
      end else begin : g_tail
         assign nbr = alu_out;
      end
      assign cell_ctrl[k].shift = rotating || (compacting && (CW'(k) >= CW'(match_ff)));
      assign cell_ctrl[k].load  = append_go && (used_ff == CW'(k));
      olist_cell u_cell (
         .clock  (clock),
         .ctrl   (cell_ctrl[k]),
         .nbr_d  (nbr),
         .load_d (req_value),
         .q      (cell_q[k])
      );
   end

   // Sequence requests and register results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         used_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= 1'b0;
         rsp_element_ff <= '0;
         rsp_pos_ff     <= '0;
         rsp_last_ff    <= 1'b1;
         rsp_status_ff  <= olist_pkg::ST_OK;
         rsp_count_ff   <= used_ff;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  op_ff    <= req_type;
                  key_ff   <= req_value;
                  step_ff  <= '0;
                  found_ff <= 1'b0;
                  case (req_type)
                     olist_pkg::REQ_APPEND: begin
                        rsp_valid_ff <= 1'b1;
                        if (used_ff == CW'(CAPACITY)) begin
                           rsp_status_ff <= olist_pkg::ST_FULL;
                        end else begin
                           used_ff      <= CW'(used_ff + CW'(1));
                           rsp_count_ff <= CW'(used_ff + CW'(1));
                        end
                     end
                     olist_pkg::REQ_REMOVE, olist_pkg::REQ_ADD,
                     olist_pkg::REQ_MUL, olist_pkg::REQ_COMB: begin
                        state_ff <= ROTATE;
                     end
                     olist_pkg::REQ_DUMP: begin
                        if (used_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= olist_pkg::ST_EMPTY;
                        end else begin
                           state_ff <= ROTATE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ROTATE: begin
               step_ff <= IW'(step_ff + IW'(1));
               if (hit) begin
                  found_ff <= 1'b1;
                  match_ff <= step_ff;
               end
               // Emit one dump result per live entry at the head
               if ((op_ff == olist_pkg::REQ_DUMP) && in_use) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_element_ff <= cell_q[0];
                  rsp_pos_ff     <= step_ff;
                  rsp_last_ff    <= dump_last;
               end
               if (last_step) begin
                  state_ff <= IDLE;
                  case (op_ff)
                     olist_pkg::REQ_REMOVE: begin
                        if (found_ff || hit) begin
                           state_ff <= COMPACT;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= olist_pkg::ST_NOTFOUND;
                        end
                     end
                     olist_pkg::REQ_DUMP: ;
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            COMPACT: begin
               used_ff      <= CW'(used_ff - CW'(1));
               rsp_count_ff <= CW'(used_ff - CW'(1));
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // Drive outputs, fitting the field widths
   logic [IW+3:0] pos_ext;
   logic [CW+4:0] cnt_ext;
   assign pos_ext         = {4'b0, rsp_pos_ff};
   assign cnt_ext         = {5'b0, rsp_count_ff};
   assign busy            = (state_ff != IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_position    = pos_ext[3:0];
   assign rsp_last        = rsp_last_ff;
   assign rsp_entry_count = cnt_ext[4:0];

   // Fill count never exceeds capacity
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // An empty status always reports an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == olist_pkg::ST_EMPTY)) |-> (rsp_entry_count == 5'd0))
      else $error("empty status with entries");

   // Gap closing always answers in the next cycle and shrinks the list
   a_compact_rsp: assert property (@(posedge clock) disable iff (reset)
      compacting |=> (rsp_valid && (rsp_status == olist_pkg::ST_OK)
                      && (used_ff == CW'($past(used_ff) - CW'(1)))))
      else $error("remove did not complete");

   // An accepted append with room grows the list by one
   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      append_go |=> (used_ff == CW'($past(used_ff) + CW'(1))))
      else $error("append did not grow list");

endmodule
`default_nettype wire
